/* hw/rtl/sfst_pkg.sv */
`timescale 1ns / 1ps

package sfst_pkg;

  localparam int unsigned BytesW = 24;
  localparam int unsigned CountW = 16;
  localparam int unsigned PagesW = 8;

  localparam logic [BytesW-1:0] BudgetReset = 24'd524288;
  localparam logic [PagesW-1:0] PagesReset  = 8'd1;
  localparam logic [CountW-1:0] CountMax    = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_ESCAPE = 2'd2,
    OP_FLUSH  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_INVALID = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_PENDING = 3'd3,
    ST_FULL    = 3'd4,
    ST_BUDGET  = 3'd5,
    ST_ESCAPE  = 3'd6,
    ST_FLUSHED = 3'd7
  } status_e;

  typedef enum logic {
    CFG_BYTE_BUDGET     = 1'b0,
    CFG_PAGES_PER_CLASS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MUL  = 2'd1,
    S_EXEC = 2'd2
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic ld_in;   // capture the input transaction
    logic ld_mul;  // register capacity and the addressed count
    logic commit;  // update state and load the output register
  } cmd_t;

endpackage

/* hw/rtl/slab_free_slot_shadow_tracker.sv */
`timescale 1ns / 1ps
// A transaction is captured, then the capacity multiply is registered with the count
//   read, then decide and update loads the output register, later if the output stalls.
// The controller takes one item at a time through the capture, multiply and update
//   steps, so no new transaction is accepted until the last one has committed.
// Reset (rst_ni low, asynchronous): all class counts and the byte total clear,
//   byte_budget = 524288, pages_per_class = 1, no result pending.
module slab_free_slot_shadow_tracker #(
  parameter int unsigned CLASS_COUNT = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] size_class, [18:3] slot_index, [34:19] run_slot_count,
  // [58:35] slot_bytes, [63:59] zero
  input  logic [63:0] s_axis_tdata,
  // [1:0] operation, [2] remote_pending
  input  logic [2:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] class_count_after, [39:16] cached_bytes_after
  output logic [39:0] m_axis_tdata,
  // [2:0] status, [3] boundary_reached
  output logic [3:0]  m_axis_tuser,
  // configuration writes, always accepted
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  sfst_pkg::cmd_t cmd;

  logic [2:0]  status;
  logic [15:0] class_count_after;
  logic [23:0] cached_bytes_after;
  logic        boundary_reached;

  assign cfg_ready_o = 1'b1;

  // Controller: idle -> multiply -> execute; execute waits on a full output
  // register, so a finished result can sit while the next item is captured.
  sfst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Datapath: config registers, per-class counts, byte total, capacity
  // multiplier and the output payload register.
  sfst_dp #(
    .CLASS_COUNT (CLASS_COUNT)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .cfg_we_i             (cfg_valid_i & cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .operation_i          (s_axis_tuser[1:0]),
    .size_class_i         (s_axis_tdata[2:0]),
    .slot_index_i         (s_axis_tdata[18:3]),
    .run_slot_count_i     (s_axis_tdata[34:19]),
    .slot_bytes_i         (s_axis_tdata[58:35]),
    .remote_pending_i     (s_axis_tuser[2]),
    .status_o             (status),
    .class_count_after_o  (class_count_after),
    .cached_bytes_after_o (cached_bytes_after),
    .boundary_reached_o   (boundary_reached)
  );

  assign m_axis_tdata = {cached_bytes_after, class_count_after};
  assign m_axis_tuser = {boundary_reached, status};

  // A commit must never overwrite a result that has not been taken.
  a_commit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before transfer");

  // The block takes one transaction at a time: busy right after acceptance.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");

  // A flush result always reports an empty cache.
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == sfst_pkg::ST_FLUSHED)
      |-> (cached_bytes_after == '0 && class_count_after == '0))
    else $error("flush left cached state");

  // The boundary flag only comes with a completed alloc or free.
  a_boundary_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && boundary_reached) |-> (status == sfst_pkg::ST_DONE))
    else $error("boundary flag on a non-done result");

endmodule

/* hw/rtl/sfst_ctrl.sv */
`timescale 1ns / 1ps

module sfst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sfst_pkg::cmd_t    cmd_o
);

  sfst_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfst_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      sfst_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = sfst_pkg::S_MUL;
        end
      end
      sfst_pkg::S_MUL: begin
        cmd_o.ld_mul = 1'b1;
        state_d      = sfst_pkg::S_EXEC;
      end
      sfst_pkg::S_EXEC: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = sfst_pkg::S_IDLE;
        end
      end
      default: state_d = sfst_pkg::S_IDLE;
    endcase

    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/sfst_dp.sv */
`timescale 1ns / 1ps

module sfst_dp #(
  parameter int unsigned CLASS_COUNT = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfst_pkg::cmd_t                cmd_i,
  // configuration write
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [sfst_pkg::BytesW-1:0]   cfg_data_i,
  // input transaction
  input  logic [1:0]                    operation_i,
  input  logic [2:0]                    size_class_i,
  input  logic [15:0]                   slot_index_i,
  input  logic [15:0]                   run_slot_count_i,
  input  logic [sfst_pkg::BytesW-1:0]   slot_bytes_i,
  input  logic                          remote_pending_i,
  // result
  output logic [2:0]                    status_o,
  output logic [sfst_pkg::CountW-1:0]   class_count_after_o,
  output logic [sfst_pkg::BytesW-1:0]   cached_bytes_after_o,
  output logic                          boundary_reached_o
);

  localparam int unsigned BytesW = sfst_pkg::BytesW;
  localparam int unsigned CountW = sfst_pkg::CountW;
  localparam int unsigned PagesW = sfst_pkg::PagesW;
  localparam int unsigned ProdW  = CountW + PagesW;

  // configuration registers
  logic [BytesW-1:0] budget_q;
  logic [PagesW-1:0] pages_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= sfst_pkg::BudgetReset;
      pages_q  <= sfst_pkg::PagesReset;
    end else if (cfg_we_i) begin
      unique case (sfst_pkg::cfg_idx_e'(cfg_index_i))
        sfst_pkg::CFG_BYTE_BUDGET:     budget_q <= cfg_data_i;
        sfst_pkg::CFG_PAGES_PER_CLASS: pages_q  <= cfg_data_i[PagesW-1:0];
        default: ;
      endcase
    end
  end

  // captured transaction
  sfst_pkg::op_e     op_q;
  logic [2:0]        cls_q;
  logic [15:0]       slot_q;
  logic [15:0]       nslots_q;
  logic [BytesW-1:0] bytes_q;
  logic              pend_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q     <= sfst_pkg::op_e'(operation_i);
      cls_q    <= size_class_i;
      slot_q   <= slot_index_i;
      nslots_q <= run_slot_count_i;
      bytes_q  <= slot_bytes_i;
      pend_q   <= remote_pending_i;
    end
  end

  // state
  logic [CountW-1:0] counts_q [CLASS_COUNT];
  logic [CountW-1:0] counts_d [CLASS_COUNT];
  logic [BytesW-1:0] total_q, total_d;

  logic cls_valid;
  assign cls_valid = {1'b0, cls_q} < 4'(CLASS_COUNT);

  logic [CountW-1:0] cnt_sel;
  always_comb begin
    cnt_sel = '0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (cls_q == 3'(c)) cnt_sel = counts_q[c];
    end
  end

  // capacity stage: one 16x8 multiply, saturated to the count width
  logic [ProdW-1:0]  prod;
  logic [CountW-1:0] cap_q;
  logic [CountW-1:0] cnt_q;

  assign prod = ProdW'(nslots_q) * ProdW'(pages_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_mul) begin
      cap_q <= (prod > ProdW'(sfst_pkg::CountMax)) ? sfst_pkg::CountMax
                                                   : prod[CountW-1:0];
      cnt_q <= cnt_sel;
    end
  end

  // decision and update
  sfst_pkg::status_e status;
  logic [CountW-1:0] cnt_new;
  logic              cnt_upd;
  logic              flush;
  logic              boundary;

  always_comb begin
    status   = sfst_pkg::ST_DONE;
    cnt_new  = cnt_q;
    cnt_upd  = 1'b0;
    flush    = 1'b0;
    boundary = 1'b0;
    total_d  = total_q;
    unique case (op_q)
      sfst_pkg::OP_ALLOC: begin
        if (!cls_valid) begin
          status = sfst_pkg::ST_INVALID;
        end else if (cnt_q == '0) begin
          status = sfst_pkg::ST_EMPTY;
        end else begin
          cnt_new  = cnt_q - CountW'(1);
          cnt_upd  = 1'b1;
          boundary = (cnt_q == CountW'(1));
          total_d  = (total_q >= bytes_q) ? total_q - bytes_q : '0;
        end
      end
      sfst_pkg::OP_FREE: begin
        if (!cls_valid || slot_q >= nslots_q) begin
          status = sfst_pkg::ST_INVALID;
        end else if (pend_q) begin
          status = sfst_pkg::ST_PENDING;
        end else if (cap_q == '0 || cnt_q >= cap_q) begin
          status = sfst_pkg::ST_FULL;
        end else if (bytes_q == '0 || bytes_q > budget_q ||
                     total_q > budget_q - bytes_q) begin
          status = sfst_pkg::ST_BUDGET;
        end else begin
          // total + bytes <= budget, so the sum fits the byte width
          cnt_new  = cnt_q + CountW'(1);
          cnt_upd  = 1'b1;
          boundary = (cnt_q + CountW'(1) == cap_q);
          total_d  = total_q + bytes_q;
        end
      end
      sfst_pkg::OP_ESCAPE: begin
        status = cls_valid ? sfst_pkg::ST_ESCAPE : sfst_pkg::ST_INVALID;
      end
      sfst_pkg::OP_FLUSH: begin
        status  = sfst_pkg::ST_FLUSHED;
        flush   = 1'b1;
        cnt_new = '0;
        total_d = '0;
      end
      default: status = sfst_pkg::ST_INVALID;
    endcase
  end

  always_comb begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (flush) begin
        counts_d[c] = '0;
      end else if (cnt_upd && cls_q == 3'(c)) begin
        counts_d[c] = cnt_new;
      end else begin
        counts_d[c] = counts_q[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CLASS_COUNT; c++) counts_q[c] <= '0;
      total_q <= '0;
    end else if (cmd_i.commit) begin
      for (int c = 0; c < CLASS_COUNT; c++) counts_q[c] <= counts_d[c];
      total_q <= total_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o             <= status;
      class_count_after_o  <= cls_valid ? cnt_new : '0;
      cached_bytes_after_o <= total_d;
      boundary_reached_o   <= boundary;
    end
  end

endmodule

/* verif/tb_slab_free_slot_shadow_tracker.sv */
`timescale 1ns / 1ps

module tb_slab_free_slot_shadow_tracker;

  localparam int unsigned NumClasses  = 6;
  localparam int unsigned CycleLimit  = 500000;
  // settle time after the last result is taken, before touching config
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned MaxReports  = 10;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS  = 2'd0,
    RX_RANDOM  = 2'd1,
    RX_PATTERN = 2'd2,
    RX_HEAVY   = 2'd3
  } rx_mode_e;

  // one allocator event
  typedef struct {
    sfst_pkg::op_e                op;
    logic [2:0]                   cls;
    logic [sfst_pkg::CountW-1:0]  slot;
    logic [sfst_pkg::CountW-1:0]  nslots;
    logic [sfst_pkg::BytesW-1:0]  bytes;
    logic                         pend;
  } slab_event_t;

  // one tracker response
  typedef struct {
    sfst_pkg::status_e            status;
    logic [sfst_pkg::CountW-1:0]  count;
    logic [sfst_pkg::BytesW-1:0]  bytes;
    logic                         boundary;
  } tracker_resp_t;

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [2:0] size_class, [18:3] slot_index, [34:19] run_slot_count,
  // [58:35] slot_bytes, [63:59] zero
  logic [63:0] s_axis_tdata;
  // [1:0] operation, [2] remote_pending
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [15:0] class_count_after, [39:16] cached_bytes_after
  logic [39:0] m_axis_tdata;
  // [2:0] status, [3] boundary_reached
  logic [3:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [23:0] cfg_data_i;

  slab_free_slot_shadow_tracker #(
    .CLASS_COUNT(NumClasses)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the tracker state and its registers
  logic [sfst_pkg::CountW-1:0] shadow_counts [8];
  logic [sfst_pkg::BytesW-1:0] shadow_bytes;
  logic [sfst_pkg::BytesW-1:0] shadow_budget;
  logic [sfst_pkg::PagesW-1:0] shadow_pages;

  tracker_resp_t     pending_resps [$];
  int unsigned       error_count = 0;

  // sender burst control
  bit                gaps_on;
  int unsigned       burst_left = 0;
  // receiver control
  rx_mode_e          rx_mode;
  logic [5:0]        rx_tick = '0;

  // per-phase shape of well-formed traffic
  logic [sfst_pkg::CountW-1:0] run_sizes   [NumClasses];
  logic [sfst_pkg::BytesW-1:0] class_bytes [NumClasses];

  // Works out the response to one event and advances the shadow state.
  function automatic tracker_resp_t track_event(slab_event_t ev);
    tracker_resp_t resp;
    logic          cls_ok;
    logic [23:0]   cap;
    int            c;
    resp.status   = sfst_pkg::ST_DONE;
    resp.boundary = 1'b0;
    cls_ok = (ev.cls < NumClasses);
    // 16b x 8b never overflows 24b; clamp to the count range
    cap = 24'(ev.nslots) * 24'(shadow_pages);
    if (cap > 24'(sfst_pkg::CountMax)) cap = 24'(sfst_pkg::CountMax);
    case (ev.op)
      sfst_pkg::OP_ALLOC: begin
        if (!cls_ok) begin
          resp.status = sfst_pkg::ST_INVALID;
        end else if (shadow_counts[ev.cls] == '0) begin
          resp.status = sfst_pkg::ST_EMPTY;
        end else begin
          shadow_counts[ev.cls] = shadow_counts[ev.cls] - 1'b1;
          resp.boundary = (shadow_counts[ev.cls] == '0);
          // byte total saturates at zero
          shadow_bytes = (shadow_bytes >= ev.bytes) ? shadow_bytes - ev.bytes : '0;
        end
      end
      sfst_pkg::OP_FREE: begin
        if (!cls_ok || ev.slot >= ev.nslots) begin
          resp.status = sfst_pkg::ST_INVALID;
        end else if (ev.pend) begin
          resp.status = sfst_pkg::ST_PENDING;
        end else if (cap == '0 || 24'(shadow_counts[ev.cls]) >= cap) begin
          resp.status = sfst_pkg::ST_FULL;
        end else if (ev.bytes == '0 || ev.bytes > shadow_budget ||
                     shadow_bytes > shadow_budget - ev.bytes) begin
          resp.status = sfst_pkg::ST_BUDGET;
        end else begin
          shadow_bytes = shadow_bytes + ev.bytes;
          shadow_counts[ev.cls] = shadow_counts[ev.cls] + 1'b1;
          resp.boundary = (24'(shadow_counts[ev.cls]) == cap);
        end
      end
      sfst_pkg::OP_ESCAPE: begin
        resp.status = cls_ok ? sfst_pkg::ST_ESCAPE : sfst_pkg::ST_INVALID;
      end
      default: begin
        for (c = 0; c < 8; c++) shadow_counts[c] = '0;
        shadow_bytes = '0;
        resp.status  = sfst_pkg::ST_FLUSHED;
      end
    endcase
    resp.count = cls_ok ? shadow_counts[ev.cls] : '0;
    resp.bytes = shadow_bytes;
    return resp;
  endfunction

  function automatic slab_event_t make_event(sfst_pkg::op_e op, logic [2:0] cls,
                                             logic [15:0] slot, logic [15:0] nslots,
                                             logic [23:0] bytes, logic pend);
    slab_event_t ev;
    ev.op     = op;
    ev.cls    = cls;
    ev.slot   = slot;
    ev.nslots = nslots;
    ev.bytes  = bytes;
    ev.pend   = pend;
    return ev;
  endfunction

  // Mostly well-formed events against the per-phase run shape, some pure noise.
  function automatic slab_event_t random_event();
    slab_event_t ev;
    int unsigned pick;
    if ($urandom_range(0, 99) < 85) begin
      pick = $urandom_range(0, 99);
      if (pick < 42)      ev.op = sfst_pkg::OP_ALLOC;
      else if (pick < 92) ev.op = sfst_pkg::OP_FREE;
      else if (pick < 97) ev.op = sfst_pkg::OP_ESCAPE;
      else                ev.op = sfst_pkg::OP_FLUSH;
      ev.cls    = 3'($urandom_range(0, NumClasses - 1));
      ev.nslots = run_sizes[ev.cls];
      // occasionally a slot just past the end of the run
      if ($urandom_range(0, 19) == 0)
        ev.slot = ev.nslots + 16'($urandom_range(0, 3));
      else
        ev.slot = 16'($urandom_range(0, ev.nslots - 1));
      ev.bytes = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 4096))
                                             : class_bytes[ev.cls];
      ev.pend  = ($urandom_range(0, 19) == 0);
    end else begin
      ev.op     = sfst_pkg::op_e'($urandom_range(0, 3));
      ev.cls    = 3'($urandom_range(0, 7));
      ev.slot   = 16'($urandom);
      ev.nslots = 16'($urandom);
      ev.bytes  = 24'($urandom);
      ev.pend   = 1'($urandom);
    end
    return ev;
  endfunction

  // Drive one event, wait for its transaction, then queue the expected response.
  task automatic send_event(input slab_event_t ev);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      @(negedge clk) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, ev.bytes, ev.nslots, ev.slot, ev.cls};
    s_axis_tuser  <= {ev.pend, ev.op};
    do @(posedge clk); while (!s_axis_tready);
    pending_resps.push_back(track_event(ev));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic write_reg(input sfst_pkg::cfg_idx_e idx, input logic [23:0] data);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    if (idx == sfst_pkg::CFG_BYTE_BUDGET) shadow_budget = data;
    else                                  shadow_pages  = data[sfst_pkg::PagesW-1:0];
    @(negedge clk) cfg_valid_i <= 1'b0;
  endtask

  // Stop sending and let every outstanding response drain out.
  task automatic drain_tracker();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_resps.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Receiver ready, updated on the falling edge
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    case (rx_mode)
      RX_ALWAYS:  m_axis_tready <= 1'b1;
      RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: m_axis_tready <= (rx_tick[2:0] != 3'd5) && (rx_tick[5:3] != 3'd7);
      default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Response checker: each result transaction against the oldest expectation
  always @(posedge clk) begin : check_resp
    tracker_resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_resps.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("unexpected result: status %0d count %0d bytes %0d boundary %0b",
                   m_axis_tuser[2:0], m_axis_tdata[15:0], m_axis_tdata[39:16],
                   m_axis_tuser[3]);
      end else begin
        want = pending_resps.pop_front();
        if (m_axis_tuser[2:0] !== want.status || m_axis_tdata[15:0] !== want.count ||
            m_axis_tdata[39:16] !== want.bytes || m_axis_tuser[3] !== want.boundary) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("mismatch exp/act: st %0d/%0d cnt %0d/%0d bytes %0d/%0d bnd %0b/%0b",
                     want.status, m_axis_tuser[2:0], want.count, m_axis_tdata[15:0],
                     want.bytes, m_axis_tdata[39:16], want.boundary, m_axis_tuser[3]);
        end
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Reset values: every error path, the field extremes, saturation on alloc.
  task automatic test_reset_defaults();
    rx_mode = RX_RANDOM;
    gaps_on = 1'b1;
    send_event(make_event(sfst_pkg::OP_ALLOC, 3'd0, 16'd0, 16'd1, 24'd8, 1'b0));
    send_event(make_event(sfst_pkg::OP_ALLOC, 3'd7, 16'd0, 16'd1, 24'd8, 1'b0));
    send_event(make_event(sfst_pkg::OP_FREE, 3'd6, 16'd0, 16'd4, 24'd100, 1'b0));
    send_event(make_event(sfst_pkg::OP_FREE, 3'd1, 16'd5, 16'd5, 24'd100, 1'b0));
    send_event(make_event(sfst_pkg::OP_FREE, 3'd1, 16'd0, 16'd4, 24'd100, 1'b1));
    send_event(make_event(sfst_pkg::OP_FREE, 3'd1, 16'd0, 16'd4, 24'd0, 1'b0));
    send_event(make_event(sfst_pkg::OP_FREE, 3'd1, 16'd3, 16'd4, 24'd524289, 1'b0));
    // fills class 0 (capacity 1) and the whole budget
    send_event(make_event(sfst_pkg::OP_FREE, 3'd0, 16'd0, 16'd1, 24'd524288, 1'b0));
    send_event(make_event(sfst_pkg::OP_FREE, 3'd0, 16'd0, 16'd1, 24'd1, 1'b0));
    send_event(make_event(sfst_pkg::OP_FREE, 3'd2, 16'd1, 16'd2, 24'd1, 1'b0));
    send_event(make_event(sfst_pkg::OP_ESCAPE, 3'd2, 16'd0, 16'd1, 24'd1, 1'b0));
    send_event(make_event(sfst_pkg::OP_ESCAPE, 3'd7, 16'd0, 16'd1, 24'd1, 1'b0));
    // alloc larger than the total saturates to zero
    send_event(make_event(sfst_pkg::OP_ALLOC, 3'd0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1));
    send_event(make_event(sfst_pkg::OP_FREE, 3'd5, 16'd65534, 16'd65535, 24'd1, 1'b0));
    send_event(make_event(sfst_pkg::OP_FREE, 3'd4, 16'd65535, 16'd65535, 24'd1, 1'b0));
    // flush with an invalid class still clears
    send_event(make_event(sfst_pkg::OP_FLUSH, 3'd7, 16'd0, 16'd0, 24'd0, 1'b0));
  endtask

  // Budget cut below what is already cached: frees refused, allocs drain.
  task automatic test_budget_lowered();
    drain_tracker();
    write_reg(sfst_pkg::CFG_BYTE_BUDGET, 24'hFFFFFF);
    write_reg(sfst_pkg::CFG_PAGES_PER_CLASS, 24'h0000FF);
    send_event(make_event(sfst_pkg::OP_FREE, 3'd3, 16'd0, 16'd65535, 24'hFFFFFF, 1'b0));
    send_event(make_event(sfst_pkg::OP_FREE, 3'd3, 16'd1, 16'd65535, 24'd1, 1'b0));
    drain_tracker();
    write_reg(sfst_pkg::CFG_BYTE_BUDGET, 24'd1000);
    send_event(make_event(sfst_pkg::OP_FREE, 3'd3, 16'd2, 16'd65535, 24'd1, 1'b0));
    send_event(make_event(sfst_pkg::OP_ALLOC, 3'd3, 16'd0, 16'd0, 24'd5, 1'b0));
    send_event(make_event(sfst_pkg::OP_ALLOC, 3'd3, 16'd0, 16'd0, 24'd5, 1'b0));
  endtask

  // Zero pages means zero capacity; zero budget refuses every free.
  task automatic test_zero_limits();
    drain_tracker();
    write_reg(sfst_pkg::CFG_PAGES_PER_CLASS, 24'hABCD00);
    send_event(make_event(sfst_pkg::OP_FREE, 3'd2, 16'd0, 16'd4, 24'd8, 1'b0));
    send_event(make_event(sfst_pkg::OP_FREE, 3'd2, 16'd0, 16'd0, 24'd8, 1'b0));
    drain_tracker();
    write_reg(sfst_pkg::CFG_BYTE_BUDGET, 24'd0);
    write_reg(sfst_pkg::CFG_PAGES_PER_CLASS, 24'd1);
    send_event(make_event(sfst_pkg::OP_FREE, 3'd2, 16'd0, 16'd4, 24'd1, 1'b0));
    send_event(make_event(sfst_pkg::OP_FLUSH, 3'd0, 16'd0, 16'd0, 24'd0, 1'b0));
  endtask

  task automatic run_random_phase(input int unsigned n_events, input logic [23:0] budget,
                                  input logic [7:0] pages, input rx_mode_e rx,
                                  input bit gaps);
    int c;
    drain_tracker();
    write_reg(sfst_pkg::CFG_BYTE_BUDGET, budget);
    // upper data bits are don't-care for the pages register
    write_reg(sfst_pkg::CFG_PAGES_PER_CLASS, {16'($urandom), pages});
    rx_mode = rx;
    gaps_on = gaps;
    for (c = 0; c < NumClasses; c++) begin
      run_sizes[c]   = 16'($urandom_range(1, 6));
      class_bytes[c] = 24'($urandom_range(1, 1500));
    end
    repeat (n_events) send_event(random_event());
  endtask

  // Random traffic across several register settings and stall patterns.
  task automatic test_random_traffic();
    run_random_phase(300, 24'd4096,   8'd1,   RX_RANDOM,  1'b1);
    run_random_phase(300, 24'd524288, 8'd2,   RX_ALWAYS,  1'b0);
    run_random_phase(250, 24'd2000,   8'd3,   RX_PATTERN, 1'b1);
    run_random_phase(200, 24'hFFFFFF, 8'd255, RX_HEAVY,   1'b1);
    run_random_phase(100, 24'd0,      8'd1,   RX_RANDOM,  1'b1);
    run_random_phase(100, 24'($urandom), 8'd0, RX_PATTERN, 1'b0);
    run_random_phase(150, 24'($urandom_range(1000, 20000)), 8'($urandom_range(1, 4)),
                     RX_RANDOM, 1'b1);
  endtask

  initial begin : main_seq
    int c;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = sfst_pkg::CFG_BYTE_BUDGET;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    rx_mode       = RX_RANDOM;
    gaps_on       = 1'b1;
    for (c = 0; c < 8; c++) shadow_counts[c] = '0;
    shadow_bytes  = '0;
    shadow_budget = sfst_pkg::BudgetReset;
    shadow_pages  = sfst_pkg::PagesReset;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_ni <= 1'b1;

    test_reset_defaults();
    test_budget_lowered();
    test_zero_limits();
    test_random_traffic();

    drain_tracker();
    if (error_count == 0 && pending_resps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* slab_free_slot_shadow_tracker.f */
hw/rtl/sfst_pkg.sv
hw/rtl/sfst_ctrl.sv
hw/rtl/sfst_dp.sv
hw/rtl/slab_free_slot_shadow_tracker.sv
verif/tb_slab_free_slot_shadow_tracker.sv
